// ----- rtl/mlpq_pkg.sv -----
`default_nettype none

package mlpq_pkg;

    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_NUM_LEVELS  = 4;

    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 3;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND       = 2'd0,
        OP_PUSH_FRONT   = 2'd1,
        OP_POP_HIGHEST  = 2'd2,
        OP_POP_LEVEL    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_LEVEL = 2'd3
    } status_t;

    // One stored task entry
    typedef struct packed {
        logic              pending;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        op_t                operation;
        logic [LEVEL_W-1:0] level;
        logic [ID_W-1:0]    task_id;
        logic [TIME_W-1:0]  arrive_stamp;
        logic               first_pending;
        logic [TIME_W-1:0]  now_time;
    } req_t;

    // Control carried from the state-update stage to the result stage
    typedef struct packed {
        logic               valid;
        status_t            status;
        logic               popped;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  now_time;
        logic               all_empty;
    } resp_ctl_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    out_task_id;
        logic [LEVEL_W-1:0] out_level;
        logic [TIME_W-1:0]  out_arrival_time;
        logic               response_valid;
        logic [TIME_W-1:0]  resp_latency;
        logic               all_empty;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/mlpq_if.sv -----
`default_nettype none

interface mlpq_in_if
    import mlpq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    task_id;
    logic [TIME_W-1:0]  arrive_stamp;
    logic               first_pending;
    logic [TIME_W-1:0]  now_time;

    modport source (
        output valid, operation, level, task_id, arrive_stamp, first_pending, now_time,
        input  ready
    );

    modport sink (
        input  valid, operation, level, task_id, arrive_stamp, first_pending, now_time,
        output ready
    );
endinterface

interface mlpq_out_if
    import mlpq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_task_id;
    logic [LEVEL_W-1:0]  out_level;
    logic [TIME_W-1:0]   out_arrival_time;
    logic                response_valid;
    logic [TIME_W-1:0]   resp_latency;
    logic                all_empty;

    modport source (
        output valid, status, out_task_id, out_level, out_arrival_time,
               response_valid, resp_latency, all_empty,
        input  ready
    );

    modport sink (
        input  valid, status, out_task_id, out_level, out_arrival_time,
               response_valid, resp_latency, all_empty,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/mlpq_store.sv -----
`default_nettype none

module mlpq_store
    import mlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    localparam int ENTRIES    = NUM_LEVELS * LEVEL_DEPTH,
    localparam int AW         = $clog2(ENTRIES)
)
(
    input  wire logic          clk,
    input  wire logic          adv,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] addr,
    input  wire entry_t        wdata,
    output entry_t             rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Hold read data while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/mlpq_ctrl.sv -----
`default_nettype none

module mlpq_ctrl
    import mlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    localparam int AW         = $clog2(NUM_LEVELS * LEVEL_DEPTH),
    localparam int IW         = $clog2(LEVEL_DEPTH),
    localparam int CW         = $clog2(LEVEL_DEPTH + 1),
    localparam int LW         = $clog2(NUM_LEVELS)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          req_valid,
    input  wire req_t          req,
    output logic               wr_en,
    output logic [AW-1:0]      addr,
    output entry_t             wdata,
    output resp_ctl_t          ctl
);

    localparam logic [CW-1:0] FULL_CNT = CW'(LEVEL_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(LEVEL_DEPTH - 1);
    localparam logic [LW-1:0] TOP_Q    = LW'(NUM_LEVELS - 1);

    logic      s1_valid_reg;
    req_t      s1_reg;
    resp_ctl_t ctl_reg;

    logic [IW-1:0] head_reg [NUM_LEVELS];
    logic [IW-1:0] tail_reg [NUM_LEVELS];
    logic [CW-1:0] cnt_reg  [NUM_LEVELS];
    logic [IW-1:0] head_next [NUM_LEVELS];
    logic [IW-1:0] tail_next [NUM_LEVELS];
    logic [CW-1:0] cnt_next  [NUM_LEVELS];

    logic          append_ok;
    logic          named_ok;
    logic [LW-1:0] lvl_q;
    logic [LW-1:0] hi_q;
    logic          any_full;
    logic [LW-1:0] sel_q;
    logic [IW-1:0] mem_idx;
    logic          wr_c;
    logic          rd_c;
    status_t       st;
    logic          empty_after;
    logic          upd;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_prev(input logic [IW-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    assign upd       = adv && s1_valid_reg;
    assign append_ok = (s1_reg.level != '0) && (32'(s1_reg.level) <= NUM_LEVELS);
    assign named_ok  = (s1_reg.level != '0) && (32'(s1_reg.level) < NUM_LEVELS);
    assign lvl_q     = LW'(s1_reg.level - 3'd1);

    // Highest non-empty level: later (higher) levels override
    always_comb
    begin
        hi_q     = '0;
        any_full = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (cnt_reg[l] != '0)
            begin
                hi_q     = LW'(l);
                any_full = 1'b1;
            end
        end
    end

    always_comb
    begin
        sel_q     = '0;
        mem_idx   = '0;
        wr_c      = 1'b0;
        rd_c      = 1'b0;
        st        = ST_OK;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        unique case (s1_reg.operation)
            OP_APPEND:
            begin
                sel_q = lvl_q;
                if (!append_ok)
                begin
                    st = ST_BAD_LEVEL;
                end
                else if (cnt_reg[lvl_q] == FULL_CNT)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    mem_idx          = tail_reg[lvl_q];
                    wr_c             = 1'b1;
                    tail_next[lvl_q] = wrap_next(tail_reg[lvl_q]);
                    cnt_next[lvl_q]  = cnt_reg[lvl_q] + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                sel_q = TOP_Q;
                if (cnt_reg[TOP_Q] == FULL_CNT)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    mem_idx          = wrap_prev(head_reg[TOP_Q]);
                    wr_c             = 1'b1;
                    head_next[TOP_Q] = mem_idx;
                    cnt_next[TOP_Q]  = cnt_reg[TOP_Q] + 1'b1;
                end
            end
            OP_POP_HIGHEST:
            begin
                sel_q = hi_q;
                if (!any_full)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    mem_idx         = head_reg[hi_q];
                    rd_c            = 1'b1;
                    head_next[hi_q] = wrap_next(head_reg[hi_q]);
                    cnt_next[hi_q]  = cnt_reg[hi_q] - 1'b1;
                end
            end
            OP_POP_LEVEL:
            begin
                sel_q = lvl_q;
                if (!named_ok)
                begin
                    st = ST_BAD_LEVEL;
                end
                else if (cnt_reg[lvl_q] == '0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    mem_idx          = head_reg[lvl_q];
                    rd_c             = 1'b1;
                    head_next[lvl_q] = wrap_next(head_reg[lvl_q]);
                    cnt_next[lvl_q]  = cnt_reg[lvl_q] - 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        empty_after = 1'b1;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (cnt_next[l] != '0)
            begin
                empty_after = 1'b0;
            end
        end
    end

    assign wr_en = wr_c && upd;
    assign addr  = AW'(32'(sel_q) * LEVEL_DEPTH + 32'(mem_idx));
    assign wdata = '{pending: s1_reg.first_pending,
                     arrival: s1_reg.arrive_stamp,
                     id:      s1_reg.task_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ctl_reg      <= '0;
            head_reg     <= '{default: '0};
            tail_reg     <= '{default: '0};
            cnt_reg      <= '{default: '0};
        end
        else if (adv)
        begin
            s1_valid_reg       <= req_valid;
            ctl_reg.valid      <= s1_valid_reg;
            ctl_reg.status     <= st;
            ctl_reg.popped     <= rd_c;
            ctl_reg.level      <= rd_c ? LEVEL_W'(32'(sel_q) + 1) : '0;
            ctl_reg.now_time   <= s1_reg.now_time;
            ctl_reg.all_empty  <= empty_after;
            if (s1_valid_reg)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // Input register: payload only
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= req;
        end
    end

    assign ctl = ctl_reg;

endmodule

`default_nettype wire

// ----- rtl/mlpq_resp.sv -----
`default_nettype none

module mlpq_resp
    import mlpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  wire resp_ctl_t ctl,
    input  wire entry_t    rdata,
    output logic           out_valid,
    output rsp_t           out
);

    logic out_valid_reg;
    rsp_t out_reg;
    rsp_t out_next;

    always_comb
    begin
        out_next                  = '0;
        out_next.status           = ctl.status;
        out_next.all_empty        = ctl.all_empty;
        if (ctl.popped)
        begin
            out_next.out_task_id      = rdata.id;
            out_next.out_level        = ctl.level;
            out_next.out_arrival_time = rdata.arrival;
            out_next.response_valid   = rdata.pending;
            if (rdata.pending)
            begin
                out_next.resp_latency = ctl.now_time - rdata.arrival;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

`default_nettype wire

// ----- rtl/multilevel_priority_queue.sv -----
// Four-level (NUM_LEVELS) priority queue of task entries, one ring per level.
// Channel req carries one operation per transaction: append at the tail of a
// level, push at the head of the top level, pop the highest non-empty level,
// or pop a named lower level. Channel rsp returns exactly one result per
// request: status, the popped entry, response time and an all-empty flag.
// Pipeline: input register, state update with store access, result register.
// rsp.valid rises once the request has passed the input register, the
// state-update register and the result register. One transaction is
// accepted per cycle while rsp is not stalled; the pointer/count update
// and the single store port each handle one operation per cycle.
// Reset empties every level (heads, tails and counts to zero) and drains the
// pipeline; the entry store itself is not cleared, since entries are read only
// after being written.
// While rsp is stalled with a result pending, the whole pipeline holds and
// req.ready stays low; no transaction is lost or repeated.
`default_nettype none

module multilevel_priority_queue
    import mlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mlpq_in_if.sink     req,
    mlpq_out_if.source  rsp
);

    localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

    logic          adv;
    req_t          req_item;
    logic          wr_en;
    logic [AW-1:0] addr;
    entry_t        wdata;
    entry_t        rdata;
    resp_ctl_t     ctl;
    logic          out_valid;
    rsp_t          out;

    // Advance everything unless a finished result is waiting
    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;

    assign req_item = '{operation:     op_t'(req.operation),
                        level:         req.level,
                        task_id:       req.task_id,
                        arrive_stamp:  req.arrive_stamp,
                        first_pending: req.first_pending,
                        now_time:      req.now_time};

    mlpq_ctrl #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req.valid),
        .req       (req_item),
        .wr_en     (wr_en),
        .addr      (addr),
        .wdata     (wdata),
        .ctl       (ctl)
    );

    mlpq_store #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_store (
        .clk   (clk),
        .adv   (adv),
        .wr_en (wr_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    mlpq_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl       (ctl),
        .rdata     (rdata),
        .out_valid (out_valid),
        .out       (out)
    );

    assign rsp.valid            = out_valid;
    assign rsp.status           = out.status;
    assign rsp.out_task_id      = out.out_task_id;
    assign rsp.out_level        = out.out_level;
    assign rsp.out_arrival_time = out.out_arrival_time;
    assign rsp.response_valid   = out.response_valid;
    assign rsp.resp_latency     = out.resp_latency;
    assign rsp.all_empty        = out.all_empty;

`ifndef SYNTHESIS
    a_fail_pops_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.out_level == '0) && !rsp.response_valid)
        else $error("failed operation returned a popped entry");

    // Read data matters only for a pop; other slots may hold never-written data
    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(ctl) && (!ctl.popped || $stable(rdata)))
        else $error("result stage changed while stalled");

    a_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && ctl.valid |=> rsp.valid)
        else $error("advanced transaction did not reach the output register");
`endif

endmodule

`default_nettype wire
